// ----- hw/rtl/sfd_pkg.sv -----
// Shared types, constants and the CRC byte update for the SPI frame decoder.
// Used by sfd_front, sfd_queue, sfd_back and the top level. No dependencies.
package sfd_pkg;

  // Frame layout
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned CRC_BYTES = 2;
  localparam int unsigned COUNT_W   = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_FLAGS   = 2'd2;
  localparam logic [1:0] REG_MAX_LEN = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  MAGIC_RESET   = 8'd0;
  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [7:0]  FLAGS_RESET   = 8'hFF;
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  // Frame status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_FLAGS   = 3'd4;
  localparam logic [2:0] ST_BAD_CRC     = 3'd5;

  // One classified byte: an optional payload result and an optional status result
  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        has_status;
    logic [2:0]  status;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [7:0]  frame_flags;
    logic [15:0] frame_id;
    logic [15:0] frame_length;
  } entry_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/spi_frame_decoder_crc16_core.sv -----
// SPI frame decoder with CRC-16/CCITT-FALSE check: top level.
// Instantiates sfd_front, sfd_queue and sfd_back; uses sfd_pkg.
//
// The block takes one received byte per clock and passes payload bytes out as
// they arrive; at the end mark it emits one status result with the header
// fields. The front end classifies a byte in the cycle it is accepted (the
// byte-wide CRC update is the longest path), so input runs at one byte per
// cycle. The output delivers one result per cycle while out_ready is high; a
// payload byte with the end mark yields two results, payload result first.
// A queue of QUEUE_DEPTH entries lets either side stall; the input stalls
// only while that queue is full. Configuration takes effect on the next byte.
module spi_frame_decoder_crc16_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_end,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [2:0]  status,
  output logic [7:0]  frame_version,
  output logic [7:0]  frame_command,
  output logic [7:0]  frame_flags,
  output logic [15:0] frame_id,
  output logic [15:0] frame_length,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sfd_pkg::entry_t push_entry;
  sfd_pkg::entry_t head_entry;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  // Accept and classify bytes
  sfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  // Decouple front and back
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (head_entry)
  );

  // Deliver results
  sfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (head_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_end         (is_end),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .status         (status),
    .frame_version  (frame_version),
    .frame_command  (frame_command),
    .frame_flags    (frame_flags),
    .frame_id       (frame_id),
    .frame_length   (frame_length)
  );

endmodule

// ----- hw/rtl/sfd_front.sv -----
// Front end of the SPI frame decoder: accepts bytes, captures the header,
// runs the CRC and classifies each byte into a queue entry. Uses sfd_pkg.
module sfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                end_of_frame,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output sfd_pkg::entry_t     q_entry
);

  logic [7:0]  magic_value;
  logic [7:0]  protocol_version;
  logic [7:0]  allowed_flag_bits;
  logic [15:0] max_payload_bytes;

  logic [sfd_pkg::COUNT_W-1:0] rx_count;
  logic [15:0] running_crc;
  logic [15:0] crc_delay_bytes;
  logic [7:0]  hdr_magic;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_command;
  logic [7:0]  hdr_flags;
  logic [15:0] hdr_id;
  logic [15:0] hdr_length;

  logic [sfd_pkg::COUNT_W-1:0] rx_count_next;
  logic [15:0] running_crc_next;
  logic [15:0] crc_delay_bytes_next;
  logic [7:0]  hdr_magic_next;
  logic [7:0]  hdr_version_next;
  logic [7:0]  hdr_command_next;
  logic [7:0]  hdr_flags_next;
  logic [15:0] hdr_id_next;
  logic [15:0] hdr_length_next;

  logic [sfd_pkg::COUNT_W-1:0] payload_off;
  logic        has_payload;
  logic [2:0]  status;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value       <= sfd_pkg::MAGIC_RESET;
      protocol_version  <= sfd_pkg::VERSION_RESET;
      allowed_flag_bits <= sfd_pkg::FLAGS_RESET;
      max_payload_bytes <= sfd_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sfd_pkg::REG_MAGIC:   magic_value       <= cfg_data[7:0];
        sfd_pkg::REG_VERSION: protocol_version  <= cfg_data[7:0];
        sfd_pkg::REG_FLAGS:   allowed_flag_bits <= cfg_data[7:0];
        sfd_pkg::REG_MAX_LEN: max_payload_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture header bytes at positions 0 to 7
  always_comb begin
    hdr_magic_next   = hdr_magic;
    hdr_version_next = hdr_version;
    hdr_command_next = hdr_command;
    hdr_flags_next   = hdr_flags;
    hdr_id_next      = hdr_id;
    hdr_length_next  = hdr_length;
    if (rx_count < sfd_pkg::COUNT_W'(sfd_pkg::HDR_BYTES)) begin
      case (rx_count[2:0])
        3'd0: hdr_magic_next       = rx_byte;
        3'd1: hdr_version_next     = rx_byte;
        3'd2: hdr_command_next     = rx_byte;
        3'd3: hdr_flags_next       = rx_byte;
        3'd4: hdr_id_next[15:8]    = rx_byte;
        3'd5: hdr_id_next[7:0]     = rx_byte;
        3'd6: hdr_length_next[15:8] = rx_byte;
        3'd7: hdr_length_next[7:0] = rx_byte;
        default: ;
      endcase
    end
  end

  // Advance CRC two bytes behind the stream, saturate the count
  always_comb begin
    running_crc_next = running_crc;
    if (rx_count >= sfd_pkg::COUNT_W'(sfd_pkg::CRC_BYTES)) begin
      running_crc_next = sfd_pkg::crc_feed(running_crc, crc_delay_bytes[15:8]);
    end
    crc_delay_bytes_next = {crc_delay_bytes[7:0], rx_byte};
    rx_count_next = (rx_count == sfd_pkg::COUNT_MAX) ? rx_count
                                                     : rx_count + 1'b1;
  end

  // Classify payload bytes
  assign payload_off = rx_count - sfd_pkg::COUNT_W'(sfd_pkg::HDR_BYTES);
  assign has_payload = (rx_count >= sfd_pkg::COUNT_W'(sfd_pkg::HDR_BYTES)) &&
                       (payload_off < {1'b0, hdr_length});

  // Check the frame in priority order
  always_comb begin
    if (rx_count_next < sfd_pkg::COUNT_W'(sfd_pkg::HDR_BYTES + sfd_pkg::CRC_BYTES)) begin
      status = sfd_pkg::ST_BAD_LENGTH;
    end else if (hdr_magic_next != magic_value) begin
      status = sfd_pkg::ST_BAD_MAGIC;
    end else if (hdr_version_next != protocol_version) begin
      status = sfd_pkg::ST_BAD_VERSION;
    end else if ((hdr_flags_next & ~allowed_flag_bits) != 8'd0) begin
      status = sfd_pkg::ST_BAD_FLAGS;
    end else if (hdr_length_next > max_payload_bytes) begin
      status = sfd_pkg::ST_BAD_LENGTH;
    end else if (rx_count_next != ({1'b0, hdr_length_next} +
                 sfd_pkg::COUNT_W'(sfd_pkg::HDR_BYTES + sfd_pkg::CRC_BYTES))) begin
      status = sfd_pkg::ST_BAD_LENGTH;
    end else if (crc_delay_bytes_next != running_crc_next) begin
      status = sfd_pkg::ST_BAD_CRC;
    end else begin
      status = sfd_pkg::ST_OK;
    end
  end

  // Build the queue entry
  always_comb begin
    q_entry.has_payload    = has_payload;
    q_entry.payload_byte   = rx_byte;
    q_entry.payload_index  = payload_off[15:0];
    q_entry.has_status     = end_of_frame;
    q_entry.status         = status;
    q_entry.frame_version  = hdr_version_next;
    q_entry.frame_command  = hdr_command_next;
    q_entry.frame_flags    = hdr_flags_next;
    q_entry.frame_id       = hdr_id_next;
    q_entry.frame_length   = hdr_length_next;
  end

  assign q_push = accept && (has_payload || end_of_frame);

  // Update frame state; clear it after the end mark
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      rx_count        <= '0;
      running_crc     <= sfd_pkg::CRC_INIT;
      crc_delay_bytes <= '0;
      hdr_magic       <= '0;
      hdr_version     <= '0;
      hdr_command     <= '0;
      hdr_flags       <= '0;
      hdr_id          <= '0;
      hdr_length      <= '0;
    end else if (accept) begin
      rx_count        <= rx_count_next;
      running_crc     <= running_crc_next;
      crc_delay_bytes <= crc_delay_bytes_next;
      hdr_magic       <= hdr_magic_next;
      hdr_version     <= hdr_version_next;
      hdr_command     <= hdr_command_next;
      hdr_flags       <= hdr_flags_next;
      hdr_id          <= hdr_id_next;
      hdr_length      <= hdr_length_next;
    end
  end

  // A closing byte leaves the frame state cleared
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_frame) |=> (rx_count == '0 && running_crc == sfd_pkg::CRC_INIT))
    else $error("frame state not cleared after end of frame");

endmodule

// ----- hw/rtl/sfd_queue.sv -----
// Short FIFO of classified entries between the decoder front and back ends.
// Uses sfd_pkg::entry_t.
module sfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sfd_pkg::entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  sfd_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/sfd_back.sv -----
// Back end of the SPI frame decoder: drains queue entries and presents each
// payload result, then the status result, on the output channel. Uses sfd_pkg.
module sfd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sfd_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            is_end,
  output logic [7:0]      payload_byte,
  output logic [15:0]     payload_index,
  output logic [2:0]      status,
  output logic [7:0]      frame_version,
  output logic [7:0]      frame_command,
  output logic [7:0]      frame_flags,
  output logic [15:0]     frame_id,
  output logic [15:0]     frame_length
);

  sfd_pkg::entry_t held;
  logic pend_payload;
  logic pend_status;
  logic deliver;
  logic last_result;

  assign out_valid   = pend_payload || pend_status;
  assign deliver     = out_valid && out_ready;
  assign last_result = pend_payload ^ pend_status;
  assign q_pop       = q_valid && (!out_valid || (deliver && last_result));

  // Present the payload result first, then the status result
  always_comb begin
    is_end = !pend_payload;
    if (pend_payload) begin
      payload_byte   = held.payload_byte;
      payload_index  = held.payload_index;
      status         = sfd_pkg::ST_OK;
      frame_version  = '0;
      frame_command  = '0;
      frame_flags    = '0;
      frame_id       = '0;
      frame_length   = '0;
    end else begin
      payload_byte   = '0;
      payload_index  = '0;
      status         = held.status;
      frame_version  = held.frame_version;
      frame_command  = held.frame_command;
      frame_flags    = held.frame_flags;
      frame_id       = held.frame_id;
      frame_length   = held.frame_length;
    end
  end

  // Hold the current entry
  always_ff @(posedge clk) begin
    if (q_pop) begin
      held <= q_head;
    end
  end

  // Track which results of the held entry remain
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_payload <= 1'b0;
      pend_status  <= 1'b0;
    end else if (q_pop) begin
      pend_payload <= q_head.has_payload;
      pend_status  <= q_head.has_status;
    end else if (deliver) begin
      if (pend_payload) begin
        pend_payload <= 1'b0;
      end else begin
        pend_status <= 1'b0;
      end
    end
  end

  a_status_follows: assert property (@(posedge clk) disable iff (rst)
    (deliver && pend_payload && pend_status) |=> (out_valid && is_end))
    else $error("status result lost after payload result");

endmodule
